// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clock, rstn, ante, cons)
`define ASSERT_NEXT(label, clock, rstn, ante, cons)

`endif

`endif

// File: rtl/ntc_pkg.sv
`timescale 1ns / 1ps

package ntc_pkg;

    localparam int NTC_SAMPLES = 10;

    localparam int ADC_W   = 10;
    localparam int SUM_W   = 14;
    localparam int CNT_W   = 4;
    localparam int TEMP_W  = 10;
    localparam int FAHR_W  = 8;
    localparam int MV_W    = 12;
    localparam int RES_W   = 23;
    localparam int DIFF_W  = 16;

    // Shared serial divider: one quotient bit per cycle.
    localparam int DIV_NUM_W = 25;
    localparam int DIV_DEN_W = 18;
    localparam int DIV_CNT_W = 5;

    localparam int NUM_SEGS = 7;
    localparam int SEG_W    = 3;

    localparam logic [DIFF_W-1:0] SEG_LO [NUM_SEGS] =
        '{16'd20311, 16'd12571, 16'd8035, 16'd5299, 16'd3587, 16'd2485, 16'd1757};
    localparam logic [DIFF_W-1:0] SEG_HI [NUM_SEGS] =
        '{16'd33969, 16'd20310, 16'd12570, 16'd8034, 16'd5298, 16'd3586, 16'd2484};
    localparam logic [DIFF_W-1:0] SEG_BASE [NUM_SEGS] =
        '{16'd33970, 16'd20310, 16'd12570, 16'd8034, 16'd5298, 16'd3586, 16'd2484};
    localparam logic [DIV_DEN_W-1:0] SEG_DIV [NUM_SEGS] =
        '{18'd136600, 18'd77400, 18'd45370, 18'd27370, 18'd17130, 18'd11030, 18'd7280};
    localparam logic [TEMP_W-1:0] SEG_OFF [NUM_SEGS] =
        '{10'd0, 10'd100, 10'd200, 10'd300, 10'd400, 10'd500, 10'd600};

    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(NUM_SEGS - 1);

    localparam logic [MV_W-1:0]   MV_FULL     = 12'd3300;
    localparam logic [13:0]       OHM_SCALE   = 14'd10000;
    localparam logic [9:0]        SEG_SCALE   = 10'd1000;
    localparam logic [FAHR_W-1:0] FAHR_OFFSET = 8'd32;
    localparam logic [DIV_DEN_W-1:0] FAHR_DEN = 18'd50;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_RES_GO,
        ST_RES_WAIT,
        ST_SCAN,
        ST_SEG_GO,
        ST_SEG_WAIT,
        ST_FAH_GO,
        ST_FAH_WAIT,
        ST_OUT
    } state_t;

    // True when the resistance lies inside segment k.
    function automatic logic seg_hit(input logic [SEG_W-1:0] k, input logic [RES_W-1:0] res);
        logic [RES_W-1:0] lo;
        logic [RES_W-1:0] hi;
        lo = RES_W'(SEG_LO[k]);
        hi = RES_W'(SEG_HI[k]);
        return (res >= lo) && (res <= hi);
    endfunction

endpackage

// File: rtl/ntc_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ntc_div
    import ntc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quotient
);

    // Restoring division: the dividend shifts out of quo_reg at the top while
    // quotient bits enter at the bottom.
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `ASSERT_SAME(a_start_idle, clk, rst_n, start, !busy_reg)
    `ASSERT_SAME(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    `ASSERT_NEXT(a_last_bit_done, clk, rst_n, busy_reg && (cnt_reg == '0) && !start, done_reg)

endmodule

// File: rtl/ntc_thermistor_temperature.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Thermistor thermometer. Each request on the slave side carries one 10-bit
// ADC sample; after every tenth sample the block averages the group,
// converts it to millivolts, works out the thermistor resistance, maps it
// through seven linear segments to tenths of a degree Celsius and derives
// whole degrees Fahrenheit, then offers one request on the master side. All
// divisions share one bit-serial divider that yields one quotient bit per
// cycle, and a result needs four divisions (three when the resistance falls
// outside the table) plus a search that tests the segments in turn. After
// the last sample of a group no sample is taken until its result is loaded
// into the output register, where it sits, so sampling resumes while it
// waits to be taken. When the resistance lies outside every segment the last
// good temperature is repeated with in_range low (0 and 32 F after reset).
module ntc_thermistor_temperature
    import ntc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] adc_sample, [15:10] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [9:0] temp_tenths_c, [17:10] temp_fahrenheit, [23:18] zero
    output logic        m_tuser    // [0] in_range
);

    state_t state_reg;
    state_t state_next;

    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TEMP_W-1:0] held_reg;
    logic [MV_W-1:0]   mv_reg;
    logic [RES_W-1:0]  res_reg;
    logic [SEG_W-1:0]  seg_reg;
    logic              ok_reg;
    logic [FAHR_W-1:0] fahr_reg;

    logic              out_valid_reg;
    logic [23:0]       out_data_reg;
    logic              out_user_reg;

    // Divider hookup.
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_q;

    logic              take_sample;
    logic              last_sample;
    logic              hit;
    logic              out_load;
    logic              div_wait;
    logic [SUM_W-1:0]  sum_plus;
    logic [21:0]       mv_product;
    logic [DIFF_W-1:0] seg_diff;

    ntc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        take_sample = s_tvalid && s_tready;
        last_sample = (count_reg == CNT_W'(NTC_SAMPLES - 1));
        hit         = seg_hit(seg_reg, res_reg);
        sum_plus    = sum_reg + SUM_W'(s_tdata[ADC_W-1:0]);
        // Millivolts from the averaged code: avg * 3300 / 1024.
        mv_product  = 22'(div_q[ADC_W-1:0]) * 22'(MV_FULL);
        seg_diff    = SEG_BASE[seg_reg] - res_reg[DIFF_W-1:0];
        div_wait    = (state_reg == ST_AVG_WAIT) || (state_reg == ST_RES_WAIT)
                   || (state_reg == ST_SEG_WAIT) || (state_reg == ST_FAH_WAIT);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC:
            begin
                if (take_sample && last_sample)
                begin
                    state_next = ST_AVG_GO;
                end
            end
            ST_AVG_GO:   state_next = ST_AVG_WAIT;
            ST_AVG_WAIT: if (div_done) state_next = ST_RES_GO;
            ST_RES_GO:   state_next = ST_RES_WAIT;
            ST_RES_WAIT: if (div_done) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_SEG_GO;
                end
                else if (seg_reg == SEG_LAST)
                begin
                    state_next = ST_FAH_GO;
                end
            end
            ST_SEG_GO:   state_next = ST_SEG_WAIT;
            ST_SEG_WAIT: if (div_done) state_next = ST_FAH_GO;
            ST_FAH_GO:   state_next = ST_FAH_WAIT;
            ST_FAH_WAIT: if (div_done) state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_ACC;
                end
            end
            default:     state_next = ST_ACC;
        endcase
    end

    // Control outputs and divider operands.
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        out_load  = 1'b0;
        case (state_reg)
            ST_ACC:
            begin
                s_tready = 1'b1;
            end
            ST_AVG_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(sum_reg);
                div_den   = DIV_DEN_W'(NTC_SAMPLES);
            end
            ST_RES_GO:
            begin
                // Resistance in ohms: mv * 10000 / (3300 - mv).
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(26'(mv_reg) * 26'(OHM_SCALE));
                div_den   = DIV_DEN_W'(MV_FULL - mv_reg);
            end
            ST_SEG_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(26'(seg_diff) * 26'(SEG_SCALE));
                div_den   = SEG_DIV[seg_reg];
            end
            ST_FAH_GO:
            begin
                // t * 9 / 5 / 10 truncates to the same value as t * 9 / 50.
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(14'(held_reg) * 14'd9);
                div_den   = FAHR_DEN;
            end
            ST_OUT:
            begin
                out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            sum_reg       <= '0;
            count_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (take_sample)
            begin
                sum_reg   <= sum_plus;
                count_reg <= last_sample ? '0 : count_reg + 1'b1;
            end
            else if (state_reg == ST_AVG_GO)
            begin
                // The divider has latched the group total; start a new group.
                sum_reg <= '0;
            end

            if ((state_reg == ST_SEG_WAIT) && div_done)
            begin
                held_reg <= div_q[TEMP_W-1:0] + SEG_OFF[seg_reg];
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working values; every one is written before it is read.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_AVG_WAIT) && div_done)
        begin
            mv_reg <= mv_product[21:10];
        end
        if ((state_reg == ST_RES_WAIT) && div_done)
        begin
            res_reg <= div_q[RES_W-1:0];
            seg_reg <= '0;
        end
        if (state_reg == ST_SCAN)
        begin
            if (hit)
            begin
                ok_reg <= 1'b1;
            end
            else
            begin
                ok_reg  <= 1'b0;
                seg_reg <= seg_reg + 1'b1;
            end
        end
        if ((state_reg == ST_FAH_WAIT) && div_done)
        begin
            fahr_reg <= div_q[FAHR_W-1:0] + FAHR_OFFSET;
        end
        if (out_load)
        begin
            out_data_reg <= {6'd0, fahr_reg, held_reg};
            out_user_reg <= ok_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `ASSERT_SAME(a_held_span, clk, rst_n, 1'b1, held_reg <= 10'd699)
    `ASSERT_SAME(a_done_in_wait, clk, rst_n, div_done, div_wait)
    `ASSERT_SAME(a_fahr_floor, clk, rst_n, out_load, fahr_reg >= FAHR_OFFSET)
    `ASSERT_SAME(a_count_span, clk, rst_n, 1'b1, count_reg < CNT_W'(NTC_SAMPLES))

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Checks the thermistor thermometer through its two stream ports. ADC samples
// are sent as requests on the slave side. A predictor in this file keeps its
// own running sum, sample count and held temperature, and for every tenth
// sample it queues the reading that the block should offer. Each request
// taken on the master side is compared, field by field, with the oldest
// queued reading.
module testbench;

    localparam int GROUP_LEN       = 10;
    localparam int BAND_COUNT      = 7;
    // Class index used for resistances that fall in no band of the table.
    localparam int OFF_TABLE       = BAND_COUNT;
    localparam int ADC_MAX         = 1023;
    localparam int MAX_IDLE        = 16;
    localparam int SETTLE_CYCLES   = 150;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 2000;

    // Resistance bands in ohms with their linear mapping to tenths of a degree:
    // t = (base - r) * 1000 / divisor + offset.
    localparam int unsigned BAND_LO [BAND_COUNT] =
        '{20311, 12571, 8035, 5299, 3587, 2485, 1757};
    localparam int unsigned BAND_HI [BAND_COUNT] =
        '{33969, 20310, 12570, 8034, 5298, 3586, 2484};
    localparam int unsigned BAND_BASE [BAND_COUNT] =
        '{33970, 20310, 12570, 8034, 5298, 3586, 2484};
    localparam int unsigned BAND_DIV [BAND_COUNT] =
        '{136600, 77400, 45370, 27370, 17130, 11030, 7280};
    localparam int unsigned BAND_OFS [BAND_COUNT] =
        '{0, 100, 200, 300, 400, 500, 600};

    typedef struct packed {
        logic [9:0] tenths_c;
        logic [7:0] fahrenheit;
        logic       in_range;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    // Predictor state, mirroring the block's accumulator and held value.
    logic [13:0] group_sum;
    int          group_count;
    logic [9:0]  held_tenths;

    reading_t    pending_readings[$];
    reading_t    taken_reading;
    int          fault_count = 0;

    // When set, neither side inserts idle cycles.
    bit          quiet = 1'b0;
    // Idle cycles still owed by the receiver after its last request.
    int          rx_wait = 0;
    // Long receiver hold-off, counted down by the receiver process.
    int          hold_left = 0;
    int          idle_cycles = 0;

    // Range of average codes that land in each class; the in-table range is
    // contiguous because the resistance rises with the average.
    int          avg_first [BAND_COUNT];
    int          avg_last  [BAND_COUNT];
    int          table_first;
    int          table_last;

    ntc_thermistor_temperature u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Thermistor resistance in ohms for a given average ADC code.
    function automatic int unsigned ohms_of_average(input logic [9:0] avg_code);
        int unsigned mv;
        mv = int'(avg_code) * 3300 / 1024;
        return mv * 10000 / (3300 - mv);
    endfunction

    function automatic int band_of_ohms(input int unsigned ohms);
        for (int k = 0; k < BAND_COUNT; k++)
        begin
            if (ohms >= BAND_LO[k] && ohms <= BAND_HI[k])
                return k;
        end
        return OFF_TABLE;
    endfunction

    // Records one accepted sample; on the last sample of a group the reading
    // that the block must offer is queued.
    task automatic take_sample(input logic [9:0] code);
        logic [9:0]  avg_code;
        int unsigned ohms;
        int          band;
        reading_t    r;
        group_sum   = group_sum + 14'(code);
        group_count = group_count + 1;
        if (group_count == GROUP_LEN)
        begin
            avg_code    = 10'(int'(group_sum) / GROUP_LEN);
            group_sum   = '0;
            group_count = 0;
            ohms        = ohms_of_average(avg_code);
            band        = band_of_ohms(ohms);
            if (band != OFF_TABLE)
                held_tenths = 10'((BAND_BASE[band] - ohms) * 1000 / BAND_DIV[band]
                                  + BAND_OFS[band]);
            r.tenths_c   = held_tenths;
            r.fahrenheit = 8'(int'(held_tenths) * 9 / 5 / 10 + 32);
            r.in_range   = (band != OFF_TABLE);
            pending_readings.push_back(r);
        end
    endtask

    task automatic map_bands();
        int band;
        table_first = ADC_MAX + 1;
        table_last  = -1;
        for (int k = 0; k < BAND_COUNT; k++)
        begin
            avg_first[k] = ADC_MAX + 1;
            avg_last[k]  = -1;
        end
        for (int a = 0; a <= ADC_MAX; a++)
        begin
            band = band_of_ohms(ohms_of_average(10'(a)));
            if (band != OFF_TABLE)
            begin
                if (a < avg_first[band])
                    avg_first[band] = a;
                avg_last[band] = a;
                if (a < table_first)
                    table_first = a;
                table_last = a;
            end
        end
    endtask

    // Offers one sample and holds it until the block takes the request, then
    // idles for a random number of cycles unless quiet is set.
    task automatic send_sample(input logic [9:0] code);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, code};
        do
            @(posedge clk);
        while (!s_tready);
        take_sample(code);
        gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Sends one whole group whose average lands in the given class. Edges of
    // each band are favoured, and the samples are either spread widely or
    // kept nearly flat, always with the same truncated average.
    task automatic send_group(input int cls);
        int avg;
        int total;
        int left;
        int lo;
        int hi;
        int v;
        bit flat;
        if (cls == OFF_TABLE)
        begin
            case ($urandom_range(0, 3))
                0:       avg = table_first - 1;
                1:       avg = table_last + 1;
                2:       avg = $urandom_range(0, table_first - 1);
                default: avg = $urandom_range(table_last + 1, ADC_MAX);
            endcase
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       avg = avg_first[cls];
                1:       avg = avg_last[cls];
                default: avg = $urandom_range(avg_first[cls], avg_last[cls]);
            endcase
        end
        total = avg * GROUP_LEN + $urandom_range(0, GROUP_LEN - 1);
        if (total > ADC_MAX * GROUP_LEN)
            total = ADC_MAX * GROUP_LEN;
        flat = ($urandom_range(0, 2) == 0);
        left = total;
        for (int i = 0; i < GROUP_LEN; i++)
        begin
            if (i == GROUP_LEN - 1)
                v = left;
            else if (flat)
                v = left / (GROUP_LEN - i);
            else
            begin
                lo = left - ADC_MAX * (GROUP_LEN - 1 - i);
                if (lo < 0)
                    lo = 0;
                hi = (left < ADC_MAX) ? left : ADC_MAX;
                v  = $urandom_range(lo, hi);
            end
            send_sample(10'(v));
            left = left - v;
        end
    endtask

    task automatic wait_drained();
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Zero input gives no resistance at all, so the first reading reports the
    // reset value (0 tenths, 32 F) out of range. Full scale gives the largest
    // millivolt value without a zero divisor and is still out of range. The
    // alternating bit patterns then average to a mid-table reading.
    task automatic test_extremes();
        repeat (GROUP_LEN) send_sample(10'd0);
        repeat (GROUP_LEN) send_sample(10'h3ff);
        repeat (GROUP_LEN / 2)
        begin
            send_sample(10'h155);
            send_sample(10'h2aa);
        end
    endtask

    // Random groups over every band and over both ends outside the table, so
    // held values follow in-range values and the reverse.
    task automatic test_bands();
        repeat (40)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            send_group($urandom_range(0, OFF_TABLE));
        end
        quiet = 1'b0;
    endtask

    // Unshaped samples: first half without idling, second half with it.
    task automatic test_random_samples();
        quiet = 1'b1;
        repeat (5 * GROUP_LEN) send_sample(10'($urandom_range(0, ADC_MAX)));
        quiet = 1'b0;
        repeat (5 * GROUP_LEN) send_sample(10'($urandom_range(0, ADC_MAX)));
    endtask

    // The receiver holds off long enough for one reading to wait in the
    // output register and a second to be finished behind it, so the block
    // has to refuse further samples while the sender keeps offering them.
    task automatic test_backpressure();
        @(negedge clk);
        s_tvalid <= 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        quiet     = 1'b1;
        repeat (4) send_group($urandom_range(0, OFF_TABLE));
        quiet     = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    // The sender stops after each group until its reading has been taken,
    // then idles a little longer, so the block starts each group from rest.
    task automatic test_drain_pause();
        repeat (8)
        begin
            send_group($urandom_range(0, OFF_TABLE));
            @(negedge clk);
            s_tvalid <= 1'b0;
            wait_drained();
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        group_sum   = '0;
        group_count = 0;
        held_tenths = '0;
        map_bands();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_bands();
        test_random_samples();
        test_backpressure();
        test_drain_pause();

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Receiver: ready changes only at the falling edge. The long hold-off
    // takes precedence over the ordinary per-request idle cycles.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait = rx_wait - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Compares every request taken on the master side with the oldest
    // queued reading, then draws the receiver's idle time for the next one.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected reading: temp_tenths_c %0d", m_tdata[9:0]);
                fault_count++;
            end
            else
            begin
                taken_reading = pending_readings.pop_front();
                if (m_tdata[9:0] !== taken_reading.tenths_c)
                begin
                    $error("temp_tenths_c: expected %0d, actual %0d",
                           taken_reading.tenths_c, m_tdata[9:0]);
                    fault_count++;
                end
                if (m_tdata[17:10] !== taken_reading.fahrenheit)
                begin
                    $error("temp_fahrenheit: expected %0d, actual %0d",
                           taken_reading.fahrenheit, m_tdata[17:10]);
                    fault_count++;
                end
                if (m_tuser !== taken_reading.in_range)
                begin
                    $error("in_range: expected %0d, actual %0d",
                           taken_reading.in_range, m_tuser);
                    fault_count++;
                end
            end
            rx_wait = quiet ? 0 : $urandom_range(0, MAX_IDLE);
        end
    end

    // Ends the run if neither side has completed a request for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/ntc_pkg.sv
rtl/ntc_div.sv
rtl/ntc_thermistor_temperature.sv
tb/sv/testbench.sv
